// ===== sv/ardc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ardc_pkg
// Shared types and constants for the adjacent relative difference counter.
// ----------------------------------------------------------------------------
package ardc_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned SLOT_W   = 16;
  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned NUM_W    = SAMPLE_W + FRAC_W;  // |cur-prev| << 16
  localparam int unsigned DEN_W    = SAMPLE_W;           // |min(cur,prev)|
  localparam int unsigned DCNT_W   = $clog2(NUM_W);

  localparam logic [COUNT_W-1:0] COUNT_CAP = {COUNT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_POST,
    ST_OUT
  } ardc_state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== sv/adjacent_relative_difference_counter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacent_relative_difference_counter_unit
// Relative difference of adjacent Q16.16 samples with a threshold hit count.
// ----------------------------------------------------------------------------
// The unit takes one request at a time. The first sample of a sequence is
// stored and gives no result (unless it is also marked last, which gives a
// single-sample result at once). Every later sample gives one result, the
// relative difference (cur-prev)/min(cur,prev) in Q16.16, truncated toward
// zero and saturated, and the last sample adds a wraparound result against
// the first sample. The quotient comes from a 48-by-32 restoring divider that
// retires one bit per cycle; a pair goes through prep, divide, the divider's
// done flag, post and output, and a last sample goes through them twice. Pairs
// with a zero operand skip the divider and go from prep to post. in_stall
// stays high from acceptance until the last result of the request has left.
// The threshold is written through cfg_* and must only change while idle.
// ----------------------------------------------------------------------------
module adjacent_relative_difference_counter_unit
  import ardc_pkg::*;
#(
  parameter int MAX_LEN = 65536
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [SAMPLE_W-1:0]        cfg_data,
  // sample requests
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last_sample,
  // results
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_rel_diff,
  output logic                       out_above,
  output logic [SLOT_W-1:0]          out_slot,
  output logic [COUNT_W-1:0]         out_count_so_far,
  output logic                       out_single,
  output logic                       out_final_res
);

  // slot stops at min(MAX_LEN-1, 65535)
  localparam logic [SLOT_W-1:0] SLOT_CAP =
    ((MAX_LEN - 1) > ((1 << SLOT_W) - 1)) ? {SLOT_W{1'b1}} : SLOT_W'(MAX_LEN - 1);

  ardc_state_t state_r, state_nxt;

  // sequence state
  logic signed [SAMPLE_W-1:0] first_r, first_nxt;
  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic [SLOT_W-1:0]          pos_r, pos_nxt;
  logic [COUNT_W-1:0]         hit_r, hit_nxt;
  logic [SAMPLE_W-1:0]        thr_r, thr_nxt;

  // working pair
  logic signed [SAMPLE_W-1:0] cur_r, cur_nxt;
  logic signed [SAMPLE_W-1:0] opnd_r, opnd_nxt;
  logic [SLOT_W-1:0]          slot_r, slot_nxt;
  logic                       wrap_r, wrap_nxt;   // wraparound pair still owed
  logic                       fin_r, fin_nxt;     // current pair is the last one
  logic                       neg_r, neg_nxt;     // quotient sign
  logic signed [SAMPLE_W-1:0] rd_r, rd_nxt;

  // result register
  logic                       ov_r, ov_nxt;
  logic signed [SAMPLE_W-1:0] o_rd_r, o_rd_nxt;
  logic                       o_above_r, o_above_nxt;
  logic [SLOT_W-1:0]          o_slot_r, o_slot_nxt;
  logic [COUNT_W-1:0]         o_cnt_r, o_cnt_nxt;
  logic                       o_single_r, o_single_nxt;
  logic                       o_fin_r, o_fin_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // combinational helpers
  logic                       in_acc;
  logic                       out_acc;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          diff_mag;
  logic signed [SAMPLE_W-1:0] den;
  logic [SAMPLE_W-1:0]        mag;
  logic                       above;
  logic                       ovf_pos;
  logic                       ovf_neg;
  logic [SAMPLE_W-1:0]        q_lo;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = ov_r && !out_stall;

  always_comb begin
    state_nxt    = state_r;
    first_nxt    = first_r;
    prev_nxt     = prev_r;
    pos_nxt      = pos_r;
    hit_nxt      = hit_r;
    thr_nxt      = thr_r;
    cur_nxt      = cur_r;
    opnd_nxt     = opnd_r;
    slot_nxt     = slot_r;
    wrap_nxt     = wrap_r;
    fin_nxt      = fin_r;
    neg_nxt      = neg_r;
    rd_nxt       = rd_r;
    ov_nxt       = ov_r;
    o_rd_nxt     = o_rd_r;
    o_above_nxt  = o_above_r;
    o_slot_nxt   = o_slot_r;
    o_cnt_nxt    = o_cnt_r;
    o_single_nxt = o_single_r;
    o_fin_nxt    = o_fin_r;

    // operand prep: numerator |cur-prev| << 16, denominator |min(cur,prev)|
    diff     = {cur_r[SAMPLE_W-1], cur_r} - {opnd_r[SAMPLE_W-1], opnd_r};
    diff_mag = diff[SAMPLE_W] ? (SAMPLE_W + 1)'(-diff) : diff;
    den      = (cur_r < opnd_r) ? cur_r : opnd_r;
    div_req.start = 1'b0;
    div_req.num   = {diff_mag[SAMPLE_W-1:0], {FRAC_W{1'b0}}};
    div_req.den   = den[SAMPLE_W-1] ? SAMPLE_W'(-den) : den;

    // saturation of the unsigned quotient
    q_lo    = div_rsp.quo[SAMPLE_W-1:0];
    ovf_pos = |div_rsp.quo[NUM_W-1:SAMPLE_W-1];
    ovf_neg = (|div_rsp.quo[NUM_W-1:SAMPLE_W]) ||
              (div_rsp.quo[SAMPLE_W-1] && (|div_rsp.quo[SAMPLE_W-2:0]));

    // threshold test on the saturated value
    mag   = rd_r[SAMPLE_W-1] ? SAMPLE_W'(-rd_r) : rd_r;
    above = mag > thr_r;

    if (cfg_valid && cfg_ready) begin
      thr_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (pos_r == '0) begin
            if (in_last_sample) begin
              // one-sample sequence
              ov_nxt       = 1'b1;
              o_rd_nxt     = '0;
              o_above_nxt  = 1'b0;
              o_slot_nxt   = '0;
              o_cnt_nxt    = '0;
              o_single_nxt = 1'b1;
              o_fin_nxt    = 1'b1;
              wrap_nxt     = 1'b0;
              first_nxt    = '0;
              prev_nxt     = '0;
              hit_nxt      = '0;
              state_nxt    = ST_OUT;
            end else begin
              first_nxt = in_sample;
              prev_nxt  = in_sample;
              pos_nxt   = SLOT_W'(1);
              hit_nxt   = '0;
            end
          end else begin
            cur_nxt  = in_sample;
            opnd_nxt = prev_r;
            slot_nxt = pos_r;
            wrap_nxt = in_last_sample;
            fin_nxt  = 1'b0;
            prev_nxt = in_sample;
            if (pos_r < SLOT_CAP) begin
              pos_nxt = pos_r + 1'b1;
            end
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        if (cur_r == '0) begin
          rd_nxt    = opnd_r;
          state_nxt = ST_POST;
        end else if (opnd_r == '0) begin
          rd_nxt    = cur_r;
          state_nxt = ST_POST;
        end else begin
          div_req.start = 1'b1;
          neg_nxt       = diff[SAMPLE_W] ^ den[SAMPLE_W-1];
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (neg_r) begin
            rd_nxt = ovf_neg ? {1'b1, {(SAMPLE_W-1){1'b0}}} : SAMPLE_W'(-q_lo);
          end else begin
            rd_nxt = ovf_pos ? {1'b0, {(SAMPLE_W-1){1'b1}}} : q_lo;
          end
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (above && (hit_r != COUNT_CAP)) begin
          hit_nxt = hit_r + 1'b1;
        end
        ov_nxt       = 1'b1;
        o_rd_nxt     = rd_r;
        o_above_nxt  = above;
        o_slot_nxt   = slot_r;
        o_cnt_nxt    = (above && (hit_r != COUNT_CAP)) ? hit_r + 1'b1 : hit_r;
        o_single_nxt = 1'b0;
        o_fin_nxt    = fin_r;
        if (fin_r) begin
          first_nxt = '0;
          prev_nxt  = '0;
          pos_nxt   = '0;
          hit_nxt   = '0;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) begin
          ov_nxt = 1'b0;
          if (wrap_r) begin
            // last sample against the first one
            opnd_nxt  = first_r;
            slot_nxt  = '0;
            wrap_nxt  = 1'b0;
            fin_nxt   = 1'b1;
            state_nxt = ST_PREP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      first_r <= '0;
      prev_r  <= '0;
      pos_r   <= '0;
      hit_r   <= '0;
      thr_r   <= '0;
      wrap_r  <= 1'b0;
      fin_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      prev_r  <= prev_nxt;
      pos_r   <= pos_nxt;
      hit_r   <= hit_nxt;
      thr_r   <= thr_nxt;
      wrap_r  <= wrap_nxt;
      fin_r   <= fin_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    opnd_r     <= opnd_nxt;
    slot_r     <= slot_nxt;
    neg_r      <= neg_nxt;
    rd_r       <= rd_nxt;
    o_rd_r     <= o_rd_nxt;
    o_above_r  <= o_above_nxt;
    o_slot_r   <= o_slot_nxt;
    o_cnt_r    <= o_cnt_nxt;
    o_single_r <= o_single_nxt;
    o_fin_r    <= o_fin_nxt;
  end

  ardc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign cfg_ready        = 1'b1;
  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = ov_r;
  assign out_rel_diff     = o_rd_r;
  assign out_above        = o_above_r;
  assign out_slot         = o_slot_r;
  assign out_count_so_far = o_cnt_r;
  assign out_single       = o_single_r;
  assign out_final_res    = o_fin_r;

  // no result is left pending once back in idle
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ov_r)
    else $error("result pending while idle");

  // a single-sample result is final and carries no count
  a_single_final: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_single_r) |-> (o_fin_r && (o_cnt_r == '0) && (o_slot_r == '0)))
    else $error("bad single-sample result");

  // divider completes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider done outside divide state");

  // a final result leaves the sequence cleared
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && o_fin_r) |=> ((pos_r == '0) && (hit_r == '0)))
    else $error("sequence not cleared after final result");

endmodule

// ===== sv/ardc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ardc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ardc_div
  import ardc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W:0]    rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;

  logic [DEN_W:0]    shifted;
  logic              ge;

  localparam logic [DCNT_W-1:0] LAST_CNT = DCNT_W'(NUM_W - 1);

  always_comb begin
    shifted  = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
    ge       = shifted >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.num;
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt = ge ? (shifted - {1'b0, den_r}) : shifted;
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_CNT) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== sim/reldiff_watch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reldiff_watch
// Watches the sample, result and threshold channels of the relative
// difference counter, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module reldiff_watch
  import ardc_pkg::*;
#(
  parameter int MAX_LEN = 65536
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [SAMPLE_W-1:0]        cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last_sample,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] out_rel_diff,
  input  logic                       out_above,
  input  logic [SLOT_W-1:0]          out_slot,
  input  logic [COUNT_W-1:0]         out_count_so_far,
  input  logic                       out_single,
  input  logic                       out_final_res,
  output int                         fail_count,
  output int                         pending,
  output int                         samples_taken,
  output int                         results_checked
);

  localparam int     SLOT_CAP = (MAX_LEN - 1 > 65535) ? 65535 : MAX_LEN - 1;
  localparam longint Q_HI     = 64'sd2147483647;
  localparam longint Q_LO     = -64'sd2147483648;

  typedef struct packed {
    logic [SAMPLE_W-1:0] rel_diff;
    logic                above;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
    logic                single;
    logic                final_res;
  } diff_result_t;

  diff_result_t               expected_diffs[$];
  logic [SAMPLE_W-1:0]        threshold;
  logic signed [SAMPLE_W-1:0] first_val;
  logic signed [SAMPLE_W-1:0] prev_val;
  logic [SLOT_W-1:0]          next_slot;
  logic [COUNT_W-1:0]         hits;
  int                         n_fail = 0;
  int                         n_in   = 0;
  int                         n_out  = 0;

  // (cur - base) / min(cur, base) in Q16.16, truncated toward zero, saturated
  function automatic logic signed [SAMPLE_W-1:0] rel_change(
    input logic signed [SAMPLE_W-1:0] cur,
    input logic signed [SAMPLE_W-1:0] base
  );
    longint c, b, d, q;
    c = cur;
    b = base;
    if (c == 0) return base;
    if (b == 0) return cur;
    d = (c < b) ? c : b;
    q = ((c - b) * 65536) / d;
    if (q > Q_HI) q = Q_HI;
    if (q < Q_LO) q = Q_LO;
    return q[SAMPLE_W-1:0];
  endfunction

  task automatic forget_sequence();
    first_val = '0;
    prev_val  = '0;
    next_slot = '0;
    hits      = '0;
  endtask

  task automatic expect_pair(
    input logic signed [SAMPLE_W-1:0] cur,
    input logic signed [SAMPLE_W-1:0] base,
    input logic [SLOT_W-1:0]          slot,
    input logic                       fin
  );
    diff_result_t r;
    longint       mag;
    r          = '0;
    r.rel_diff = rel_change(cur, base);
    mag        = longint'($signed(r.rel_diff));
    if (mag < 0) mag = -mag;
    r.above = mag > longint'(threshold);
    if (r.above && hits != COUNT_CAP) hits = hits + 1'b1;
    r.slot      = slot;
    r.count     = hits;
    r.final_res = fin;
    expected_diffs.push_back(r);
  endtask

  task automatic predict_sample(
    input logic signed [SAMPLE_W-1:0] s,
    input logic                       last
  );
    diff_result_t r;
    if (next_slot == '0) begin
      if (last) begin
        // lone sample: one result, nothing to compare against
        r           = '0;
        r.single    = 1'b1;
        r.final_res = 1'b1;
        expected_diffs.push_back(r);
        forget_sequence();
      end else begin
        first_val = s;
        prev_val  = s;
        next_slot = 1;
        hits      = '0;
      end
    end else begin
      expect_pair(s, prev_val, next_slot, 1'b0);
      prev_val = s;
      if (next_slot < SLOT_CAP) next_slot = next_slot + 1'b1;
      if (last) begin
        // wraparound pair: last sample against the first
        expect_pair(s, first_val, '0, 1'b1);
        forget_sequence();
      end
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    diff_result_t e;
    if (!rst_n) begin
      threshold = '0;
      forget_sequence();
      expected_diffs.delete();
    end else begin
      if (out_valid && !out_stall) begin
        n_out++;
        if (expected_diffs.size() == 0) begin
          $error("result with nothing expected: rel_diff %0d slot %0d final %0b",
                 out_rel_diff, out_slot, out_final_res);
          n_fail++;
        end else begin
          e = expected_diffs.pop_front();
          check_field("rel_diff", $signed(e.rel_diff), out_rel_diff);
          check_field("above", e.above, out_above);
          check_field("slot", e.slot, out_slot);
          check_field("count_so_far", e.count, out_count_so_far);
          check_field("single", e.single, out_single);
          check_field("final_res", e.final_res, out_final_res);
        end
      end
      if (cfg_valid && cfg_ready) threshold = cfg_data;
      if (in_valid && !in_stall) begin
        n_in++;
        predict_sample(in_sample, in_last_sample);
      end
    end
    fail_count      <= n_fail;
    pending         <= expected_diffs.size();
    samples_taken   <= n_in;
    results_checked <= n_out;
  end

endmodule

// ===== sim/adjacent_relative_difference_counter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacent_relative_difference_counter_unit_test
// Drives sample sequences into the relative difference counter and checks
// every result against a prediction made by reldiff_watch.
// ----------------------------------------------------------------------------
// A short directed run hits lone samples, zero operands, full-scale operands
// and both saturation directions. Seven random phases follow, each with its
// own threshold (zero, all ones and values around 1.0 among them), written
// only while the unit is idle. Sequences are mostly short so that the
// wraparound and lone-sample paths come often. Sender and receiver insert
// random gaps, except in phases run back to back, and once the receiver
// holds off for a long stretch so the unit backs up its input.
// ----------------------------------------------------------------------------
module adjacent_relative_difference_counter_unit_test
  import ardc_pkg::*;
;

  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES      = 7;
  localparam int SETTLE_CYCLES   = 150;  // longer than one last-sample request
  localparam int HOLD_CYCLES     = 400;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [SAMPLE_W-1:0]        cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_last_sample;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_rel_diff;
  logic                       out_above;
  logic [SLOT_W-1:0]          out_slot;
  logic [COUNT_W-1:0]         out_count_so_far;
  logic                       out_single;
  logic                       out_final_res;

  int fails;
  int pending;
  int samples_in;
  int results_out;

  // pacing knobs for the sender and the receiver, and a threshold write count
  int send_gap_max = 8;
  int recv_gap_max = 8;
  int hold_off     = 0;
  int thr_writes   = 0;

  logic signed [SAMPLE_W-1:0] last_sent = '0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  adjacent_relative_difference_counter_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_last_sample   (in_last_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rel_diff     (out_rel_diff),
    .out_above        (out_above),
    .out_slot         (out_slot),
    .out_count_so_far (out_count_so_far),
    .out_single       (out_single),
    .out_final_res    (out_final_res)
  );

  reldiff_watch watch (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_last_sample   (in_last_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rel_diff     (out_rel_diff),
    .out_above        (out_above),
    .out_slot         (out_slot),
    .out_count_so_far (out_count_so_far),
    .out_single       (out_single),
    .out_final_res    (out_final_res),
    .fail_count       (fails),
    .pending          (pending),
    .samples_taken    (samples_in),
    .results_checked  (results_out)
  );

  // Offer one sample request and return at the edge that takes it. valid is
  // left high: the next call either replaces the payload in the same step or
  // drops valid for its gap, so valid sees one assignment per step.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= s;
    in_last_sample <= last;
    do @(posedge clk); while (in_stall);
    last_sent = s;
  endtask

  // Drop valid, wait out every expected result, then allow for a request
  // that gives no result but may still keep the unit busy.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [SAMPLE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_writes++;
  endtask

  // Sample mix: zeros, full-scale corners, raw random words, small values of
  // either sign, values a small fraction away from the previous sample so that
  // relative differences land near typical thresholds, and the previous sample repeated or negated.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(
    input logic signed [SAMPLE_W-1:0] prv
  );
    logic signed [SAMPLE_W-1:0] nudge;
    logic signed [SAMPLE_W-1:0] mag;
    nudge = prv >>> $urandom_range(1, 14);
    mag   = $urandom_range(1, 32'h0006_0000);
    case ($urandom_range(0, 9))
      0: return '0;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      2, 3: return $urandom;
      4, 5: return $urandom_range(0, 1) ? -mag : mag;
      6, 7, 8: return $urandom_range(0, 1) ? prv + nudge : prv - nudge;
      default: return $urandom_range(0, 1) ? prv : -prv;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] phase_threshold(input int p);
    case (p)
      0: return 32'h0000_8000;  // 0.5
      1: return 32'hFFFF_FFFF;  // nothing can exceed
      2: return 32'h0001_0000;  // 1.0
      3: return 32'h0000_0000;  // any nonzero counts
      4: return 32'h7FFF_FFFF;  // only a magnitude of 2^31 counts
      5: return 32'h0000_0400;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stall before each result; a pending hold-off request
  // from the stimulus replaces the draw once.
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        n        = hold_off;
        hold_off = 0;
      end else begin
        n = $urandom_range(0, recv_gap_max);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int sent;
    int seq_len;
    rst_n          <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_sample      <= '0;
    in_last_sample <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests, threshold still at its reset value of zero.
    push_sample(32'sh0005_0000, 1'b1);  // lone sample
    push_sample(32'sh0000_0000, 1'b0);  // all-zero pair and wraparound
    push_sample(32'sh0000_0000, 1'b1);
    push_sample(32'sh0001_0000, 1'b0);
    push_sample(32'sh0000_0000, 1'b0);  // zero cur passes prev through
    push_sample(32'sh0003_0000, 1'b0);  // zero prev passes cur through
    push_sample(32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sh8000_0000, 1'b0);  // full-scale swing
    push_sample(32'sh0000_0001, 1'b0);
    push_sample(32'sh7FFF_FFFF, 1'b0);  // divide by one ulp: saturates high
    push_sample(32'shFFFF_FFFF, 1'b0);
    push_sample(32'sh7FFF_FFFF, 1'b0);  // negative divisor: saturates low
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(32'sh0001_0000, 1'b0);
    push_sample(32'sh0001_0000, 1'b0);  // equal samples
    push_sample(32'shFFFF_0000, 1'b1);  // sign flip, wraparound vs first
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(32'sh8000_0000, 1'b1);
    push_sample(32'shFFFF_FFFF, 1'b0);
    push_sample(32'sh0000_0001, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_threshold(phase_threshold(p));
      // every third phase runs back to back on both sides
      send_gap_max = (p % 3 == 1) ? 0 : 8;
      recv_gap_max = send_gap_max;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4: seq_len = 1;
          17, 18, 19: seq_len = $urandom_range(7, 30);
          default: seq_len = $urandom_range(2, 6);
        endcase
        for (int k = 0; k < seq_len; k++) begin
          push_sample(pick_sample(last_sent), k == seq_len - 1);
          sent++;
          // long output hold while samples keep coming
          if (p == 2 && sent == 40) hold_off = HOLD_CYCLES;
        end
      end
    end

    settle();
    $display("Summary: %0d sample requests, %0d results compared, %0d threshold settings",
             samples_in, results_out, thr_writes);
    $display("Summary: sequences of 1..30 samples, zero and full-scale operands, both %s",
             "saturation directions, paced and back-to-back traffic, one long output hold");
    if (fails == 0 && pending == 0) begin
      $display("adjacent_relative_difference_counter_unit_test passed");
    end else begin
      $display("adjacent_relative_difference_counter_unit_test failed");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #20_000_000;
    $display("adjacent_relative_difference_counter_unit_test failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/ardc_pkg.sv
sv/ardc_div.sv
sv/adjacent_relative_difference_counter_unit.sv
sim/reldiff_watch.sv
sim/adjacent_relative_difference_counter_unit_test.sv
